[hdl/ksf_pkg.sv]
// Shared types, codes and sizes for the kinetic scroll fling block.
package ksf_pkg;

  localparam int HIST_DEPTH = 10;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

  localparam int POS_W      = 16;
  localparam int TS_W       = 32;
  localparam int DAMP_W     = 16;
  localparam int WIN_W      = 8;
  localparam int THR_W      = 16;
  localparam int VALUE_W    = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_W     = 16;
  localparam int DMAG_W     = POS_W;
  localparam int DVD_W      = DMAG_W + FRAC_W + 2;
  localparam int VMAG_W     = DVD_W;
  localparam int VEL_W      = VMAG_W + 1;
  localparam int ACC_W      = VMAG_W + DAMP_W;
  localparam int STEP_W     = $clog2(DVD_W);
  localparam int PX_W       = VMAG_W - FRAC_W + 1;

  localparam logic [2:0] MODE_DOWN       = 3'd0;
  localparam logic [2:0] MODE_MOVE       = 3'd1;
  localparam logic [2:0] MODE_UP         = 3'd2;
  localparam logic [2:0] MODE_FLING      = 3'd3;
  localparam logic [2:0] MODE_FLING_DAMP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DAMPING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD  = 2'd2;

  localparam logic [DAMP_W-1:0] RST_DEFAULT_DAMPING = 16'd55705;
  localparam logic [WIN_W-1:0]  RST_MAX_WINDOW      = 8'd25;
  localparam logic [THR_W-1:0]  RST_STOP_THRESHOLD  = 16'd6554;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_MUL,
    ST_FLING,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             sub;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
  } alu_req_t;

endpackage

[hdl/ksf_addsub.sv]
// Shared add/subtract unit used by the serial divider and the serial multiplier.
module ksf_addsub
  import ksf_pkg::*;
(
  input  alu_req_t       req,
  output logic [ACC_W:0] sum
);

  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule

[hdl/kinetic_scroll_fling_core.sv]
// Top level of the kinetic scroll fling calculator.
//
// Input channel in_valid/in_ready carries one pointer event per item: mode,
// position, timestamp and damp_factor. Output channel out_valid/out_ready
// returns exactly one result item (value, flag) per input item, in order.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
// One item is worked on at a time; in_ready is high only in the idle state.
// Down, move and ignored events go from decode straight to the result. In
// fling events, 16 shift-add steps of the shared adder form the damping
// product. In up events that start a fling, 34 restoring division steps on
// the same adder form the velocity quotient.
// The next item is accepted at the earliest once the result has been loaded
// into the output register and the state has returned to idle.
// The result waits in an output register, so a new item is accepted while
// the receiver stalls; the next result is held back until that register frees.
// Reset clears pressed, sample count, velocity and out_valid, enters idle and
// loads the register defaults. History entries are undefined until written.
module kinetic_scroll_fling_core
  import ksf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  mode,
  input  logic signed [POS_W-1:0]     position,
  input  logic [TS_W-1:0]             timestamp,
  input  logic [DAMP_W-1:0]           damp_factor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VALUE_W-1:0]   value,
  output logic                        flag,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  state_t state, state_next;

  logic [DAMP_W-1:0] default_damping;
  logic [WIN_W-1:0]  max_window;
  logic [THR_W-1:0]  stop_threshold;

  logic                    pressed;
  logic [CNT_W-1:0]        sample_count;
  logic signed [VEL_W-1:0] velocity;
  logic [STEP_W-1:0]       step;

  logic signed [POS_W-1:0] point_history [HIST_DEPTH];
  logic [TS_W-1:0]         time_history  [HIST_DEPTH];
  logic signed [POS_W-1:0] last_point;

  logic [2:0]              m_mode;
  logic signed [POS_W-1:0] m_pos;
  logic [TS_W-1:0]         m_ts;
  logic [DAMP_W-1:0]       m_damp;

  logic [DVD_W-1:0]  dvd;
  logic [WIN_W-1:0]  rem;
  logic [WIN_W-1:0]  divisor;
  logic              neg;
  logic [ACC_W-1:0]  acc;
  logic [VMAG_W-1:0] mmag;
  logic [DAMP_W-1:0] mfac;

  logic signed [VALUE_W-1:0] res_value;
  logic                      res_flag;

  alu_req_t         alu_req;
  logic [ACC_W:0]   alu_sum;

  logic [TS_W-1:0]         elapsed;
  logic [TS_W-1:0]         elapsed_adj;
  logic                    up_ok;
  logic signed [POS_W-1:0] cur_point;
  logic signed [POS_W:0]   diff;
  logic [POS_W:0]          diff_abs;
  logic [VEL_W-1:0]        vel_abs;
  logic [WIN_W:0]          rem_sh;
  logic                    qbit;
  logic [VMAG_W-1:0]       nmag;
  logic                    below;
  logic [VMAG_W:0]         ceil_sum;
  logic [PX_W-1:0]         px_pos;
  logic [PX_W-1:0]         px_neg;
  logic                    out_room;
  logic                    div_last;
  logic                    mul_last;

  ksf_addsub u_addsub (
    .req (alu_req),
    .sum (alu_sum)
  );

  always_comb begin
    elapsed     = m_ts - time_history[0];
    elapsed_adj = (elapsed == '0) ? TS_W'(1) : elapsed;
    up_ok       = elapsed_adj <= TS_W'(max_window);
    cur_point   = (m_pos == '0) ? last_point : m_pos;
    diff        = (POS_W + 1)'(point_history[0]) - (POS_W + 1)'(cur_point);
    diff_abs    = diff[POS_W] ? -diff : diff;
    vel_abs     = velocity[VEL_W-1] ? -velocity : velocity;
    rem_sh      = {rem, dvd[DVD_W-1]};
    qbit        = !alu_sum[ACC_W];
    nmag        = acc[ACC_W-1:DAMP_W];
    below       = nmag < VMAG_W'(stop_threshold);
    ceil_sum    = {1'b0, nmag} + (VMAG_W + 1)'({FRAC_W{1'b1}});
    px_pos      = ceil_sum[VMAG_W:FRAC_W];
    px_neg      = {1'b0, nmag[VMAG_W-1:FRAC_W]};
    out_room    = !out_valid || out_ready;
    div_last    = step == STEP_W'(DVD_W - 1);
    mul_last    = step == STEP_W'(DAMP_W - 1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (m_mode == MODE_UP && pressed && up_ok) begin
          state_next = ST_DIV;
        end else if (m_mode == MODE_FLING || m_mode == MODE_FLING_DAMP) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_last) state_next = ST_DONE;
      end
      ST_MUL: begin
        if (mul_last) state_next = ST_FLING;
      end
      ST_FLING: state_next = ST_DONE;
      ST_DONE: begin
        if (out_room) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = state == ST_IDLE;
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state)
      ST_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ACC_W'(rem_sh);
        alu_req.b   = ACC_W'(divisor);
      end
      ST_MUL: begin
        alu_req.a = {acc[ACC_W-2:0], 1'b0};
        alu_req.b = mfac[DAMP_W-1] ? ACC_W'(mmag) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      default_damping <= RST_DEFAULT_DAMPING;
      max_window      <= RST_MAX_WINDOW;
      stop_threshold  <= RST_STOP_THRESHOLD;
      pressed         <= 1'b0;
      sample_count    <= '0;
      velocity        <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEFAULT_DAMPING: default_damping <= cfg_data[DAMP_W-1:0];
          CFG_MAX_WINDOW:      max_window      <= cfg_data[WIN_W-1:0];
          CFG_STOP_THRESHOLD:  stop_threshold  <= cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_DECODE) begin
        unique case (m_mode)
          MODE_DOWN: begin
            pressed      <= 1'b1;
            velocity     <= '0;
            sample_count <= CNT_W'(1);
          end
          MODE_MOVE: begin
            if (pressed && sample_count != CNT_W'(HIST_DEPTH)) begin
              sample_count <= sample_count + CNT_W'(1);
            end
          end
          MODE_UP: begin
            pressed <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_DIV && div_last) begin
        velocity <= neg ? -$signed({1'b0, dvd[DVD_W-2:0], qbit})
                        : $signed({1'b0, dvd[DVD_W-2:0], qbit});
      end
      if (state == ST_FLING) begin
        velocity <= neg ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});
      end
      if (state == ST_DONE && out_room) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_mode <= mode;
      m_pos  <= position;
      m_ts   <= timestamp;
      m_damp <= damp_factor;
    end
    unique case (state)
      ST_DECODE: begin
        res_value <= '0;
        res_flag  <= 1'b0;
        step      <= '0;
        rem       <= '0;
        acc       <= '0;
        dvd       <= {diff_abs[DMAG_W-1:0], {(DVD_W - DMAG_W){1'b0}}};
        divisor   <= elapsed_adj[WIN_W-1:0];
        mmag      <= vel_abs[VMAG_W-1:0];
        mfac      <= (m_mode == MODE_FLING_DAMP) ? m_damp : default_damping;
        unique case (m_mode)
          MODE_DOWN: begin
            point_history[0] <= m_pos;
            time_history[0]  <= m_ts;
            last_point       <= m_pos;
          end
          MODE_MOVE: begin
            if (pressed) begin
              res_value  <= VALUE_W'(last_point) - VALUE_W'(m_pos);
              res_flag   <= 1'b1;
              last_point <= m_pos;
              if (sample_count == CNT_W'(HIST_DEPTH)) begin
                for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                  point_history[i] <= point_history[i+1];
                  time_history[i]  <= time_history[i+1];
                end
                point_history[HIST_DEPTH-1] <= m_pos;
                time_history[HIST_DEPTH-1]  <= m_ts;
              end else begin
                point_history[sample_count[IDX_W-1:0]] <= m_pos;
                time_history[sample_count[IDX_W-1:0]]  <= m_ts;
              end
            end
          end
          MODE_UP: begin
            neg <= diff[POS_W];
          end
          default: begin
            neg <= velocity[VEL_W-1];
          end
        endcase
      end
      ST_DIV: begin
        step <= step + STEP_W'(1);
        rem  <= qbit ? alu_sum[WIN_W-1:0] : rem_sh[WIN_W-1:0];
        dvd  <= {dvd[DVD_W-2:0], qbit};
        if (div_last) res_flag <= 1'b1;
      end
      ST_MUL: begin
        step <= step + STEP_W'(1);
        acc  <= alu_sum[ACC_W-1:0];
        mfac <= {mfac[DAMP_W-2:0], 1'b0};
      end
      ST_FLING: begin
        priority if (below) begin
          res_value <= '0;
        end else if (neg) begin
          res_value <= -$signed(VALUE_W'(px_neg));
        end else begin
          res_value <= $signed(VALUE_W'(px_pos));
        end
      end
      ST_DONE: begin
        if (out_room) begin
          value <= res_value;
          flag  <= res_flag;
        end
      end
      default: begin
      end
    endcase
  end

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (divisor != '0))
    else $error("divider running with zero divisor");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(HIST_DEPTH))
    else $error("sample count past history depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after item accepted");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_room) |=> (out_valid && state == ST_IDLE))
    else $error("finished item not delivered to output register");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for kinetic_scroll_fling_core: drag gestures, flings, register sweeps.
module tb;
  import ksf_pkg::*;

  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT      = 18;
  localparam int REPORT_CAP    = 200;
  localparam longint PX_MAX    = (64'sd1 <<< (VALUE_W - 1)) - 1;
  localparam longint PX_MIN    = -(64'sd1 <<< (VALUE_W - 1));

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      flag;
  } fling_result_t;

  class fling_scoreboard;
    bit                      pressed;
    int                      used;
    logic signed [POS_W-1:0] pos_hist[HIST_DEPTH];
    logic [TS_W-1:0]         tick_hist[HIST_DEPTH];
    longint                  velocity;
    logic [DAMP_W-1:0]       damping;
    logic [WIN_W-1:0]        window;
    logic [THR_W-1:0]        threshold;
    fling_result_t           expected_q[$];
    int                      errors;

    function new();
      pressed   = 1'b0;
      used      = 0;
      velocity  = 0;
      damping   = RST_DEFAULT_DAMPING;
      window    = RST_MAX_WINDOW;
      threshold = RST_STOP_THRESHOLD;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEFAULT_DAMPING: damping = data;
        CFG_MAX_WINDOW:      window = data[WIN_W-1:0];
        CFG_STOP_THRESHOLD:  threshold = data;
        default: ;
      endcase
    endfunction

    function int newest();
      return (used == 0) ? 0 : used - 1;
    endfunction

    function longint damp_velocity(logic [DAMP_W-1:0] factor);
      longint mag;
      longint px;
      velocity = velocity * longint'(factor) / 65536;
      mag = (velocity < 0) ? -velocity : velocity;
      if (mag < longint'(threshold)) return 0;
      if (velocity >= 0) px = (mag + 65535) >>> 16;
      else px = -(mag >>> 16);
      if (px > PX_MAX) px = PX_MAX;
      if (px < PX_MIN) px = PX_MIN;
      return px;
    endfunction

    function void note_event(logic [2:0] m, logic signed [POS_W-1:0] p,
                             logic [TS_W-1:0] ts, logic [DAMP_W-1:0] d);
      fling_result_t           r;
      logic signed [POS_W-1:0] cur;
      logic [TS_W-1:0]         span;
      int                      i;
      r = '0;
      case (m)
        MODE_DOWN: begin
          pressed      = 1'b1;
          velocity     = 0;
          used         = 1;
          pos_hist[0]  = p;
          tick_hist[0] = ts;
        end
        MODE_MOVE: begin
          if (pressed) begin
            r.value = VALUE_W'(longint'(pos_hist[newest()]) - longint'(p));
            if (used == HIST_DEPTH) begin
              for (i = 0; i < HIST_DEPTH - 1; i++) begin
                pos_hist[i]  = pos_hist[i + 1];
                tick_hist[i] = tick_hist[i + 1];
              end
            end else begin
              used++;
            end
            pos_hist[newest()]  = p;
            tick_hist[newest()] = ts;
            r.flag = 1'b1;
          end
        end
        MODE_UP: begin
          if (pressed) begin
            cur     = (p == 0) ? pos_hist[newest()] : p;
            span    = ts - tick_hist[0];
            pressed = 1'b0;
            if (span == 0) span = 1;
            if (span <= TS_W'(window)) begin
              velocity = (longint'(pos_hist[0]) - longint'(cur)) * 4 * 65536 / longint'(span);
              r.flag   = 1'b1;
            end
          end
        end
        MODE_FLING:      r.value = VALUE_W'(damp_velocity(damping));
        MODE_FLING_DAMP: r.value = VALUE_W'(damp_velocity(d));
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic signed [VALUE_W-1:0] v, logic f);
      fling_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item value %0d flag %0b", v, f));
        return;
      end
      want = expected_q.pop_front();
      if (v !== want.value) report($sformatf("value got %0d expected %0d", v, want.value));
      if (f !== want.flag) report($sformatf("flag got %0b expected %0b", f, want.flag));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [2:0]                mode;
  logic signed [POS_W-1:0]   position;
  logic [TS_W-1:0]           timestamp;
  logic [DAMP_W-1:0]         damp_factor;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      flag;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  bit                        calm = 1'b0;
  int                        cycles = 0;
  logic [TS_W-1:0]           tick;
  int                        k;
  fling_scoreboard           sb;

  kinetic_scroll_fling_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(value, flag);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] m, input logic signed [POS_W-1:0] p,
                            input logic [TS_W-1:0] ts, input logic [DAMP_W-1:0] d);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    position    <= p;
    timestamp   <= ts;
    damp_factor <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_event(m, p, ts, d);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_gesture(inout int count);
    logic signed [POS_W-1:0] p;
    logic [TS_W-1:0]         ts;
    int                      moves;
    int                      flings;
    p      = POS_W'($urandom);
    ts     = $urandom;
    moves  = $urandom_range(0, 14);
    flings = $urandom_range(0, 8);
    send_event(MODE_DOWN, p, ts, DAMP_W'($urandom));
    repeat (moves) begin
      ts += ($urandom_range(99) < 5) ? $urandom_range(0, 400) : $urandom_range(0, 4);
      if ($urandom_range(99) < 10) p = POS_W'($urandom);
      else p = POS_W'(int'(p) + int'($urandom_range(0, 1200)) - 600);
      send_event(MODE_MOVE, p, ts, DAMP_W'($urandom));
    end
    ts += ($urandom_range(99) < 10) ? $urandom_range(0, 300) : $urandom_range(0, 4);
    if ($urandom_range(1) == 1) p = POS_W'(int'(p) + int'($urandom_range(0, 1200)) - 600);
    send_event(MODE_UP, ($urandom_range(99) < 20) ? '0 : p, ts, DAMP_W'($urandom));
    repeat (flings) begin
      if ($urandom_range(1) == 1) begin
        send_event(MODE_FLING, POS_W'($urandom), $urandom, DAMP_W'($urandom));
      end else begin
        send_event(MODE_FLING_DAMP, POS_W'($urandom), $urandom,
                   DAMP_W'(($urandom_range(99) < 60) ? $urandom_range(40000, 65535) : $urandom));
      end
    end
    count += 2 + moves + flings;
  endtask

  task automatic run_noise(inout int count);
    logic [2:0] m;
    m = 3'($urandom_range(0, 7));
    send_event(m, POS_W'($urandom), $urandom, DAMP_W'($urandom));
    if (m <= MODE_FLING_DAMP) count++;
  endtask

  task automatic run_random(input int n);
    int count;
    count = 0;
    while (count < n) begin
      if ($urandom_range(9) < 8) run_gesture(count);
      else run_noise(count);
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = '0;
    position    = '0;
    timestamp   = '0;
    damp_factor = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    sb = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // ignored while released, a fling at rest, then an unused mode
    send_event(MODE_MOVE, 16'sd100, 32'd5, 16'd0);
    send_event(MODE_UP, 16'sd100, 32'd6, 16'd0);
    send_event(MODE_FLING, 16'sd0, 32'd7, 16'd0);
    send_event(MODE_RSVD_LO, -16'sd1, '1, '1);
    // full history with one drop, tick wrap, up at position zero
    tick = 32'hFFFF_FFFA;
    send_event(MODE_DOWN, 16'sh7FFF, tick, 16'd0);
    for (k = 0; k < HIST_DEPTH; k++) begin
      tick += 1;
      send_event(MODE_MOVE, (k == 0) ? 16'sh8000 : POS_W'(-32768 + 3000 * k), tick, 16'hFFFF);
    end
    tick += 1;
    send_event(MODE_UP, 16'sd0, tick, 16'd0);
    send_event(MODE_FLING_DAMP, 16'sd0, 32'd0, 16'hFFFF);
    send_event(MODE_FLING, 16'sd0, 32'd0, 16'd0);
    send_event(MODE_FLING_DAMP, 16'sd0, 32'd0, 16'd0);
    // zero elapsed time at full swing
    send_event(MODE_DOWN, 16'sh8000, 32'd500, 16'd0);
    send_event(MODE_UP, 16'sh7FFF, 32'd500, 16'd0);
    send_event(MODE_FLING_DAMP, 16'sd0, 32'd0, 16'hFFFF);
    // backwards tick, then span past the window
    send_event(MODE_DOWN, 16'sd10, 32'd1000, 16'd0);
    send_event(MODE_UP, 16'sd20, 32'd999, 16'd0);
    send_event(MODE_FLING, 16'sd0, 32'd0, 16'd0);
    send_event(MODE_DOWN, 16'sd0, 32'd0, 16'd0);
    send_event(MODE_UP, 16'sd5, 32'd26, 16'd0);
    send_event(MODE_RSVD_HI, 16'sd1, 32'd0, 16'd0);

    run_random(300);
    settle();

    calm = 1'b1;
    write_reg(CFG_DEFAULT_DAMPING, 16'hFFFF);
    write_reg(CFG_MAX_WINDOW, 16'd255);
    write_reg(CFG_STOP_THRESHOLD, 16'd0);
    run_random(250);
    settle();
    calm = 1'b0;

    write_reg(CFG_DEFAULT_DAMPING, 16'd0);
    write_reg(CFG_MAX_WINDOW, 16'd1);
    write_reg(CFG_STOP_THRESHOLD, 16'hFFFF);
    run_random(200);
    settle();

    write_reg(CFG_DEFAULT_DAMPING, CFG_DATA_W'($urandom_range(45000, 65535)));
    write_reg(CFG_MAX_WINDOW, CFG_DATA_W'($urandom_range(2, 60)));
    write_reg(CFG_STOP_THRESHOLD, CFG_DATA_W'($urandom_range(0, 20000)));
    run_random(300);
    settle();

    write_reg(CFG_DEFAULT_DAMPING, 16'd32768);
    write_reg(CFG_MAX_WINDOW, 16'd8);
    write_reg(CFG_STOP_THRESHOLD, 16'd1);
    run_random(250);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[kinetic_scroll_fling_core.f]
hdl/ksf_pkg.sv
hdl/ksf_addsub.sv
hdl/kinetic_scroll_fling_core.sv
tb/sv/tb.sv
